>>> hw/rtl/soft_knee_saturation_top_assert.svh
// ----------------------------------------------------------------------------
// Soft-knee saturation assertion macros
// Shared property forms for the concurrent checks of the top level.
// ----------------------------------------------------------------------------
`ifndef SOFT_KNEE_SATURATION_TOP_ASSERT_SVH
`define SOFT_KNEE_SATURATION_TOP_ASSERT_SVH

// Overlapping implication, checked outside reset.
`define SKNS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("soft knee saturation check failed");

// Implication on the following clock edge, checked outside reset.
`define SKNS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("soft knee saturation check failed");

`endif

>>> hw/rtl/skns_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soft-knee saturation package
// Register indexes, region codes and the control word of the pipeline.
// ----------------------------------------------------------------------------
package skns_pkg;

   localparam int CSR_INDEX_WIDTH = 4;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_LOWER_LEVEL  = 4'd0,
      CSR_UPPER_LEVEL  = 4'd1,
      CSR_LOWER_MARGIN = 4'd2,
      CSR_UPPER_MARGIN = 4'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      REGION_FLOOR     = 3'd0,
      REGION_LOW_KNEE  = 3'd1,
      REGION_PASS      = 3'd2,
      REGION_HIGH_KNEE = 3'd3,
      REGION_CEIL      = 3'd4
   } region_type;

   typedef struct packed {
      logic       valid;
      region_type region;
   } skns_ctrl_type;

endpackage

>>> hw/rtl/skns_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soft-knee saturation channels
// Sample, level and register-write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface skns_sample_if #(
   parameter int DATA_WIDTH = 32
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface skns_level_if #(
   parameter int DATA_WIDTH = 32
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] level;

   modport source (output valid, output level, input ready);
   modport sink (input valid, input level, output ready);
endinterface

interface skns_csr_if #(
   parameter int DATA_WIDTH = 32
);
   logic                                  valid;
   logic                                  ready;
   logic [skns_pkg::CSR_INDEX_WIDTH-1:0]  index;
   logic [DATA_WIDTH-1:0]                 data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/skns_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soft-knee saturation region decode
// Compares the sample with the four knee boundaries and forms the knee offset.
// ----------------------------------------------------------------------------
module skns_front #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en_i,
   input  logic                          valid_i,
   input  logic signed [DATA_WIDTH-1:0]  sample_i,
   input  logic signed [DATA_WIDTH-1:0]  lower_level_i,
   input  logic signed [DATA_WIDTH-1:0]  upper_level_i,
   input  logic [DATA_WIDTH-3:0]         lower_margin_i,
   input  logic [DATA_WIDTH-3:0]         upper_margin_i,
   output skns_pkg::skns_ctrl_type       ctrl_o,
   output logic [DATA_WIDTH-1:0]         base_o,
   output logic [DATA_WIDTH-2:0]         mag_o,
   output logic [DATA_WIDTH-3:0]         margin_o
);

   localparam int MW = DATA_WIDTH - 2;
   localparam int EW = DATA_WIDTH + 2;

   logic signed [EW-1:0]    x_ext;
   logic signed [EW-1:0]    a_ext;
   logic signed [EW-1:0]    b_ext;
   logic signed [EW-1:0]    sa_ext;
   logic signed [EW-1:0]    sb_ext;
   logic signed [EW-1:0]    lo_start;
   logic signed [EW-1:0]    lo_end;
   logic signed [EW-1:0]    up_start;
   logic signed [EW-1:0]    up_end;
   logic signed [EW-1:0]    d_lo;
   logic signed [EW-1:0]    d_up;

   skns_pkg::region_type    region_in;
   logic [DATA_WIDTH-1:0]   base_in;
   logic [DATA_WIDTH-2:0]   mag_in;
   logic [MW-1:0]           margin_in;

   skns_pkg::skns_ctrl_type ctrl_ff;
   logic [DATA_WIDTH-1:0]   base_ff;
   logic [DATA_WIDTH-2:0]   mag_ff;
   logic [MW-1:0]           margin_ff;

   assign x_ext    = {{2{sample_i[DATA_WIDTH-1]}}, sample_i};
   assign a_ext    = {{2{lower_level_i[DATA_WIDTH-1]}}, lower_level_i};
   assign b_ext    = {{2{upper_level_i[DATA_WIDTH-1]}}, upper_level_i};
   assign sa_ext   = {{(EW-MW){1'b0}}, lower_margin_i};
   assign sb_ext   = {{(EW-MW){1'b0}}, upper_margin_i};
   assign lo_start = a_ext - sa_ext;
   assign lo_end   = a_ext + sa_ext;
   assign up_start = b_ext - sb_ext;
   assign up_end   = b_ext + sb_ext;
   assign d_lo     = x_ext - lo_start;
   assign d_up     = up_end - x_ext;

   always_comb begin
      region_in = skns_pkg::REGION_CEIL;
      base_in   = upper_level_i;
      mag_in    = '0;
      margin_in = '0;
      if (x_ext < lo_start) begin
         region_in = skns_pkg::REGION_FLOOR;
         base_in   = lower_level_i;
      end else if (x_ext < lo_end) begin
         region_in = skns_pkg::REGION_LOW_KNEE;
         base_in   = lower_level_i;
         mag_in    = d_lo[DATA_WIDTH-2:0];
         margin_in = lower_margin_i;
      end else if (x_ext < up_start) begin
         region_in = skns_pkg::REGION_PASS;
         base_in   = sample_i;
      end else if (x_ext < up_end) begin
         region_in = skns_pkg::REGION_HIGH_KNEE;
         mag_in    = d_up[DATA_WIDTH-2:0];
         margin_in = upper_margin_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else if (en_i) begin
         ctrl_ff <= '{valid: valid_i, region: region_in};
      end
   end

   always_ff @(posedge clock) begin
      if (en_i) begin
         base_ff   <= base_in;
         mag_ff    <= mag_in;
         margin_ff <= margin_in;
      end
   end

   assign ctrl_o   = ctrl_ff;
   assign base_o   = base_ff;
   assign mag_o    = mag_ff;
   assign margin_o = margin_ff;

endmodule

>>> hw/rtl/skns_square.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soft-knee saturation square
// Squares the knee offset in two stages: two half-width products, then a sum.
// ----------------------------------------------------------------------------
module skns_square #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en_i,
   input  skns_pkg::skns_ctrl_type       ctrl_i,
   input  logic [DATA_WIDTH-1:0]         base_i,
   input  logic [DATA_WIDTH-2:0]         mag_i,
   input  logic [DATA_WIDTH-3:0]         margin_i,
   output skns_pkg::skns_ctrl_type       ctrl_o,
   output logic [DATA_WIDTH-1:0]         base_o,
   output logic [2*DATA_WIDTH-5:0]       num_o,
   output logic [DATA_WIDTH-3:0]         margin_o
);

   localparam int MAGW = DATA_WIDTH - 1;
   localparam int HALF = DATA_WIDTH / 2;
   localparam int PLW  = MAGW + HALF;
   localparam int PHW  = MAGW + (MAGW - HALF);
   localparam int SQW  = 2 * MAGW;

   logic [PLW-1:0]          p_lo_in;
   logic [PHW-1:0]          p_hi_in;
   logic [SQW-1:0]          sq_in;

   skns_pkg::skns_ctrl_type ctrl1_ff;
   logic [DATA_WIDTH-1:0]   base1_ff;
   logic [DATA_WIDTH-3:0]   margin1_ff;
   logic [PLW-1:0]          p_lo_ff;
   logic [PHW-1:0]          p_hi_ff;

   skns_pkg::skns_ctrl_type ctrl2_ff;
   logic [DATA_WIDTH-1:0]   base2_ff;
   logic [DATA_WIDTH-3:0]   margin2_ff;
   logic [SQW-1:0]          sq_ff;

   assign p_lo_in = PLW'(mag_i) * PLW'(mag_i[HALF-1:0]);
   assign p_hi_in = PHW'(mag_i) * PHW'(mag_i[MAGW-1:HALF]);
   assign sq_in   = SQW'(p_lo_ff) + (SQW'(p_hi_ff) << HALF);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl1_ff.valid <= 1'b0;
         ctrl2_ff.valid <= 1'b0;
      end else if (en_i) begin
         ctrl1_ff <= ctrl_i;
         ctrl2_ff <= ctrl1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_i) begin
         base1_ff   <= base_i;
         margin1_ff <= margin_i;
         p_lo_ff    <= p_lo_in;
         p_hi_ff    <= p_hi_in;
         base2_ff   <= base1_ff;
         margin2_ff <= margin1_ff;
         sq_ff      <= sq_in;
      end
   end

   // The knee term is sq / (4 * margin), taken as (sq / 4) / margin.
   assign ctrl_o   = ctrl2_ff;
   assign base_o   = base2_ff;
   assign num_o    = sq_ff[SQW-1:2];
   assign margin_o = margin2_ff;

endmodule

>>> hw/rtl/skns_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soft-knee saturation divider
// Pipelined restoring division, one quotient bit per stage, most significant
// bit first.
// ----------------------------------------------------------------------------
module skns_divider #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en_i,
   input  skns_pkg::skns_ctrl_type       ctrl_i,
   input  logic [DATA_WIDTH-1:0]         base_i,
   input  logic [2*DATA_WIDTH-5:0]       num_i,
   input  logic [DATA_WIDTH-3:0]         margin_i,
   output skns_pkg::skns_ctrl_type       ctrl_o,
   output logic [DATA_WIDTH-1:0]         base_o,
   output logic [DATA_WIDTH-3:0]         quot_o
);

   localparam int MW = DATA_WIDTH - 2;
   localparam int NW = 2 * MW;

   skns_pkg::skns_ctrl_type ctrl_ff [MW];
   logic [DATA_WIDTH-1:0]   base_ff [MW];
   logic [MW-1:0]           quot_ff [MW];
   logic [MW-1:0]           quot_in [MW];
   logic [NW-1:0]           rem_ff [MW-1];
   logic [MW-1:0]           margin_ff [MW-1];

   for (genvar j = 0; j < MW; j++) begin : g_stage
      localparam int K = MW - 1 - j;

      skns_pkg::skns_ctrl_type ctrl_prev;
      logic [DATA_WIDTH-1:0]   base_prev;
      logic [NW-1:0]           rem_prev;
      logic [MW-1:0]           margin_prev;
      logic [MW-1:0]           quot_prev;
      logic [NW-1:0]           div_shift;
      logic                    fits;

      if (j == 0) begin : g_first
         assign ctrl_prev   = ctrl_i;
         assign base_prev   = base_i;
         assign rem_prev    = num_i;
         assign margin_prev = margin_i;
         assign quot_prev   = '0;
      end else begin : g_next
         assign ctrl_prev   = ctrl_ff[j-1];
         assign base_prev   = base_ff[j-1];
         assign rem_prev    = rem_ff[j-1];
         assign margin_prev = margin_ff[j-1];
         assign quot_prev   = quot_ff[j-1];
      end

      assign div_shift = NW'(margin_prev) << K;
      assign fits      = rem_prev >= div_shift;

      always_comb begin
         quot_in[j]    = quot_prev;
         quot_in[j][K] = fits;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctrl_ff[j].valid <= 1'b0;
         end else if (en_i) begin
            ctrl_ff[j] <= ctrl_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en_i) begin
            base_ff[j] <= base_prev;
            quot_ff[j] <= quot_in[j];
         end
      end

      if (j < MW - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en_i) begin
               rem_ff[j]    <= fits ? (rem_prev - div_shift) : rem_prev;
               margin_ff[j] <= margin_prev;
            end
         end
      end
   end

   assign ctrl_o = ctrl_ff[MW-1];
   assign base_o = base_ff[MW-1];
   assign quot_o = quot_ff[MW-1];

endmodule

>>> hw/rtl/skns_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soft-knee saturation output
// Applies the knee term with saturation and buffers results in an output
// register backed by a skid register.
// ----------------------------------------------------------------------------
module skns_back #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  skns_pkg::skns_ctrl_type       ctrl_i,
   input  logic [DATA_WIDTH-1:0]         base_i,
   input  logic [DATA_WIDTH-3:0]         quot_i,
   input  logic                          rsp_ready_i,
   output logic                          rsp_valid_o,
   output logic [DATA_WIDTH-1:0]         rsp_level_o,
   output logic                          en_o
);

   localparam int MW = DATA_WIDTH - 2;
   localparam int WW = DATA_WIDTH + 1;

   logic signed [WW-1:0]  base_ext;
   logic signed [WW-1:0]  quot_ext;
   logic signed [WW-1:0]  wide;
   logic [DATA_WIDTH-1:0] knee_level;
   logic [DATA_WIDTH-1:0] level_in;
   logic                  en;
   logic                  take;

   logic                  pipe_valid_ff;
   logic [DATA_WIDTH-1:0] pipe_level_ff;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic [DATA_WIDTH-1:0] out_ff;
   logic [DATA_WIDTH-1:0] out_in;
   logic                  skid_valid_ff;
   logic                  skid_valid_in;
   logic [DATA_WIDTH-1:0] skid_ff;
   logic [DATA_WIDTH-1:0] skid_in;

   assign base_ext = {base_i[DATA_WIDTH-1], base_i};
   assign quot_ext = {{(WW-MW){1'b0}}, quot_i};
   assign wide     = (ctrl_i.region == skns_pkg::REGION_LOW_KNEE) ? (base_ext + quot_ext)
                                                                  : (base_ext - quot_ext);

   always_comb begin
      if (wide[WW-1] != wide[WW-2]) begin
         knee_level = {wide[WW-1], {(DATA_WIDTH-1){~wide[WW-1]}}};
      end else begin
         knee_level = wide[DATA_WIDTH-1:0];
      end
   end

   always_comb begin
      case (ctrl_i.region)
         skns_pkg::REGION_LOW_KNEE,
         skns_pkg::REGION_HIGH_KNEE: begin
            level_in = knee_level;
         end
         default: begin
            level_in = base_i;
         end
      endcase
   end

   assign en   = !skid_valid_ff;
   assign take = out_valid_ff && rsp_ready_i;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (pipe_valid_ff) begin
         if (!out_valid_ff || take) begin
            out_valid_in = 1'b1;
            out_in       = pipe_level_ff;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = pipe_level_ff;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (en) begin
            pipe_valid_ff <= ctrl_i.valid;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pipe_level_ff <= level_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid_o = out_valid_ff;
   assign rsp_level_o = out_ff;
   assign en_o        = en;

endmodule

>>> hw/rtl/soft_knee_saturation_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soft-knee saturation
// Clamps signed fixed-point samples between two levels with quadratic knees.
// ----------------------------------------------------------------------------
// Samples enter on req_if and saturated levels leave on rsp_if; both channels
// move one word at a clock edge where valid and ready are high. The four
// registers (lower level, upper level, lower margin, upper margin) are written
// through csr_if, which is always ready. The user must write them only while
// no sample is in flight; the block itself does not enforce this. A word
// passes one decode stage, two multiply stages, DATA_WIDTH - 2 divider stages
// (one quotient bit each), one saturation stage and the output register. The
// pipeline accepts one word per cycle while the skid register is empty.
// Reset clears all valid bits and loads lower level 0, upper level the largest
// positive value and both margins 0.
// When rsp_if stalls, the output register holds its word and one more word
// lands in the skid register; req_if.ready then drops until the skid register
// drains, and the whole pipeline holds without losing or repeating a word.
// ----------------------------------------------------------------------------
`include "soft_knee_saturation_top_assert.svh"

module soft_knee_saturation_top #(
   parameter int DATA_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   skns_sample_if.sink  req_if,
   skns_level_if.source rsp_if,
   skns_csr_if.sink     csr_if
);

   localparam int MW = DATA_WIDTH - 2;

   logic signed [DATA_WIDTH-1:0] lower_level_ff;
   logic signed [DATA_WIDTH-1:0] upper_level_ff;
   logic [MW-1:0]                lower_margin_ff;
   logic [MW-1:0]                upper_margin_ff;

   logic                         pipe_en;

   skns_pkg::skns_ctrl_type      front_ctrl;
   logic [DATA_WIDTH-1:0]        front_base;
   logic [DATA_WIDTH-2:0]        front_mag;
   logic [MW-1:0]                front_margin;

   skns_pkg::skns_ctrl_type      sq_ctrl;
   logic [DATA_WIDTH-1:0]        sq_base;
   logic [2*MW-1:0]              sq_num;
   logic [MW-1:0]                sq_margin;

   skns_pkg::skns_ctrl_type      div_ctrl;
   logic [DATA_WIDTH-1:0]        div_base;
   logic [MW-1:0]                div_quot;

   logic [DATA_WIDTH-1:0]        rsp_level;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_level_ff  <= '0;
         upper_level_ff  <= {1'b0, {(DATA_WIDTH-1){1'b1}}};
         lower_margin_ff <= '0;
         upper_margin_ff <= '0;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            skns_pkg::CSR_LOWER_LEVEL: begin
               lower_level_ff <= csr_if.data;
            end
            skns_pkg::CSR_UPPER_LEVEL: begin
               upper_level_ff <= csr_if.data;
            end
            skns_pkg::CSR_LOWER_MARGIN: begin
               lower_margin_ff <= csr_if.data[MW-1:0];
            end
            skns_pkg::CSR_UPPER_MARGIN: begin
               upper_margin_ff <= csr_if.data[MW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign req_if.ready = pipe_en;

   skns_front #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .en_i           (pipe_en),
      .valid_i        (req_if.valid),
      .sample_i       (req_if.sample),
      .lower_level_i  (lower_level_ff),
      .upper_level_i  (upper_level_ff),
      .lower_margin_i (lower_margin_ff),
      .upper_margin_i (upper_margin_ff),
      .ctrl_o         (front_ctrl),
      .base_o         (front_base),
      .mag_o          (front_mag),
      .margin_o       (front_margin)
   );

   skns_square #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_square (
      .clock    (clock),
      .reset    (reset),
      .en_i     (pipe_en),
      .ctrl_i   (front_ctrl),
      .base_i   (front_base),
      .mag_i    (front_mag),
      .margin_i (front_margin),
      .ctrl_o   (sq_ctrl),
      .base_o   (sq_base),
      .num_o    (sq_num),
      .margin_o (sq_margin)
   );

   skns_divider #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .en_i     (pipe_en),
      .ctrl_i   (sq_ctrl),
      .base_i   (sq_base),
      .num_i    (sq_num),
      .margin_i (sq_margin),
      .ctrl_o   (div_ctrl),
      .base_o   (div_base),
      .quot_o   (div_quot)
   );

   skns_back #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .ctrl_i      (div_ctrl),
      .base_i      (div_base),
      .quot_i      (div_quot),
      .rsp_ready_i (rsp_if.ready),
      .rsp_valid_o (rsp_if.valid),
      .rsp_level_o (rsp_level),
      .en_o        (pipe_en)
   );

   assign rsp_if.level = rsp_level;

   // A knee offset never exceeds twice its margin, and a knee never has a zero margin.
   `SKNS_ASSERT_SAME(a_knee_offset_bound, clock, reset,
      front_ctrl.valid && (front_ctrl.region == skns_pkg::REGION_LOW_KNEE ||
                           front_ctrl.region == skns_pkg::REGION_HIGH_KNEE),
      (front_mag <= {front_margin, 1'b0}) && (front_margin != '0))

   // Input backpressure only arises while a result is waiting at the output.
   `SKNS_ASSERT_SAME(a_stall_needs_result, clock, reset, !req_if.ready, rsp_if.valid)

   // A held pipeline keeps its first stage unchanged.
   `SKNS_ASSERT_NEXT(a_stall_holds_front, clock, reset, !pipe_en, $stable(front_ctrl))

endmodule

>>> sim/skns_level_predictor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soft-knee saturation level predictor
// Watches the sample, level and register channels, computes the saturated
// level of every accepted sample from its own copy of the registers, and
// compares each returned level in order with the oldest prediction.
// ----------------------------------------------------------------------------
module skns_level_predictor #(
   parameter int DATA_WIDTH = 32
) (
   input  logic   clock,
   input  logic   reset,
   skns_sample_if req_if,
   skns_level_if  rsp_if,
   skns_csr_if    csr_if,
   output int     mismatch_count,
   output int     outstanding,
   output int     levels_compared,
   output int     low_knee_hits,
   output int     high_knee_hits
);

   localparam int MARGIN_WIDTH = DATA_WIDTH - 2;
   localparam longint LEVEL_MAX = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
   localparam longint LEVEL_MIN = -LEVEL_MAX - 1;

   typedef longint unsigned wide_unsigned_type;

   typedef struct {
      logic signed [DATA_WIDTH-1:0] sample;
      logic signed [DATA_WIDTH-1:0] level;
   } level_prediction_type;

   longint lower_level;
   longint upper_level;
   longint lower_margin;
   longint upper_margin;
   level_prediction_type pending_levels[$];

   // The square of the offset divided by four times the margin, truncated.
   function automatic longint knee_drop(input longint offset, input longint margin);
      wide_unsigned_type magnitude;
      magnitude = (offset < 0) ? -offset : offset;
      return longint'((magnitude * magnitude) / (wide_unsigned_type'(margin) * 4));
   endfunction

   function automatic logic signed [DATA_WIDTH-1:0] saturate_sample(
      input  logic signed [DATA_WIDTH-1:0] sample_in,
      output skns_pkg::region_type         region
   );
      longint x;
      longint result;
      longint lo_start;
      longint lo_end;
      longint up_start;
      longint up_end;
      x = sample_in;
      lo_start = lower_level - lower_margin;
      lo_end = lower_level + lower_margin;
      up_start = upper_level - upper_margin;
      up_end = upper_level + upper_margin;
      if (x < lo_start) begin
         result = lower_level;
         region = skns_pkg::REGION_FLOOR;
      end else if (x < lo_end) begin
         result = lower_level + knee_drop(x - lo_start, lower_margin);
         region = skns_pkg::REGION_LOW_KNEE;
      end else if (x < up_start) begin
         result = x;
         region = skns_pkg::REGION_PASS;
      end else if (x < up_end) begin
         result = upper_level - knee_drop(x - up_end, upper_margin);
         region = skns_pkg::REGION_HIGH_KNEE;
      end else begin
         result = upper_level;
         region = skns_pkg::REGION_CEIL;
      end
      if (result > LEVEL_MAX) begin
         result = LEVEL_MAX;
      end else if (result < LEVEL_MIN) begin
         result = LEVEL_MIN;
      end
      return result[DATA_WIDTH-1:0];
   endfunction

   always @(posedge clock) begin : track
      level_prediction_type entry;
      skns_pkg::region_type region;
      if (reset) begin
         lower_level = 0;
         upper_level = LEVEL_MAX;
         lower_margin = 0;
         upper_margin = 0;
         pending_levels.delete();
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               skns_pkg::CSR_LOWER_LEVEL:
                  lower_level = longint'($signed(csr_if.data));
               skns_pkg::CSR_UPPER_LEVEL:
                  upper_level = longint'($signed(csr_if.data));
               skns_pkg::CSR_LOWER_MARGIN:
                  lower_margin = longint'(csr_if.data[MARGIN_WIDTH-1:0]);
               skns_pkg::CSR_UPPER_MARGIN:
                  upper_margin = longint'(csr_if.data[MARGIN_WIDTH-1:0]);
               default: ;
            endcase
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_levels.size() == 0) begin
               mismatch_count++;
               $display("%0t: level %0d arrived with no word outstanding",
                        $time, rsp_if.level);
            end else begin
               entry = pending_levels.pop_front();
               levels_compared++;
               if (rsp_if.level !== entry.level) begin
                  mismatch_count++;
                  $display("%0t: level mismatch for sample %0d: expected %0d, got %0d",
                           $time, entry.sample, entry.level, rsp_if.level);
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            entry.sample = req_if.sample;
            entry.level = saturate_sample(req_if.sample, region);
            if (region == skns_pkg::REGION_LOW_KNEE) begin
               low_knee_hits++;
            end
            if (region == skns_pkg::REGION_HIGH_KNEE) begin
               high_knee_hits++;
            end
            pending_levels.push_back(entry);
         end
      end
      outstanding = pending_levels.size();
   end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soft-knee saturation testbench
// Drives directed edge samples and then random samples aimed at the knees
// under a series of register settings, with random idle cycles on both
// channels, a long output stall and a mid-run drain; the level predictor
// checks every returned word.
// ----------------------------------------------------------------------------
module tb;

   localparam int DATA_WIDTH = 32;
   localparam int MARGIN_WIDTH = DATA_WIDTH - 2;
   localparam int CSR_INDEX_BITS = skns_pkg::CSR_INDEX_WIDTH;
   localparam longint LEVEL_MAX = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
   localparam longint LEVEL_MIN = -LEVEL_MAX - 1;
   localparam longint MARGIN_MAX = (longint'(1) << MARGIN_WIDTH) - 1;
   localparam longint Q_ONE = longint'(1) << 16;
   localparam int SETTING_COUNT = 8;
   localparam int SAMPLES_PER_SETTING = 112;
   localparam int LONG_STALL_CYCLES = 200;
   localparam int DRAIN_CYCLES = DATA_WIDTH + 8;

   logic   clock;
   logic   reset;
   int     send_idle_pct;
   int     recv_idle_pct;
   bit     hold_request = 0;
   int     samples_sent;
   int     settings_applied;
   longint cur_lower;
   longint cur_upper;
   longint cur_lower_margin;
   longint cur_upper_margin;
   int     mismatch_count;
   int     outstanding;
   int     levels_compared;
   int     low_knee_hits;
   int     high_knee_hits;

   skns_sample_if #(.DATA_WIDTH(DATA_WIDTH)) req_if ();
   skns_level_if #(.DATA_WIDTH(DATA_WIDTH)) rsp_if ();
   skns_csr_if #(.DATA_WIDTH(DATA_WIDTH)) csr_if ();

   soft_knee_saturation_top #(.DATA_WIDTH(DATA_WIDTH)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   skns_level_predictor #(.DATA_WIDTH(DATA_WIDTH)) level_predictor (
      .clock           (clock),
      .reset           (reset),
      .req_if          (req_if),
      .rsp_if          (rsp_if),
      .csr_if          (csr_if),
      .mismatch_count  (mismatch_count),
      .outstanding     (outstanding),
      .levels_compared (levels_compared),
      .low_knee_hits   (low_knee_hits),
      .high_knee_hits  (high_knee_hits)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_if.ready = 1'b0;
         end else if (hold_request) begin
            rsp_if.ready = 1'b0;
            repeat (LONG_STALL_CYCLES - 1) @(negedge clock);
            hold_request = 0;
         end else begin
            rsp_if.ready = ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Uniform in [-span, span]; span must stay below 2**31.
   function automatic longint spread(input longint span);
      return longint'($urandom_range(0, 32'(2 * span))) - span;
   endfunction

   function automatic longint pick_sample();
      longint edges[4];
      edges = '{cur_lower - cur_lower_margin, cur_lower + cur_lower_margin,
                cur_upper - cur_upper_margin, cur_upper + cur_upper_margin};
      case ($urandom_range(0, 5))
         0, 1:    return longint'($signed($urandom));
         2:       return cur_lower + spread(cur_lower_margin + 4);
         3:       return cur_upper + spread(cur_upper_margin + 4);
         4:       return edges[$urandom_range(0, 3)] + spread(1);
         default: return spread(longint'(1) << 20);
      endcase
   endfunction

   task automatic send_sample(input longint value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid = 1'b1;
      req_if.sample = value[DATA_WIDTH-1:0];
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      samples_sent++;
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [DATA_WIDTH-1:0]     data);
      csr_if.valid = 1'b1;
      csr_if.index = index;
      csr_if.data = data;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   task automatic wait_drained();
      req_if.valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // Margins go out with junk in the bits above their width.
   task automatic apply_setting(input longint lower, input longint upper,
                                input longint lower_margin, input longint upper_margin);
      logic [1:0] pad;
      wait_drained();
      pad = 2'($urandom);
      write_register(skns_pkg::CSR_LOWER_LEVEL, lower[DATA_WIDTH-1:0]);
      write_register(skns_pkg::CSR_UPPER_LEVEL, upper[DATA_WIDTH-1:0]);
      write_register(skns_pkg::CSR_LOWER_MARGIN, {pad, lower_margin[MARGIN_WIDTH-1:0]});
      write_register(skns_pkg::CSR_UPPER_MARGIN, {~pad, upper_margin[MARGIN_WIDTH-1:0]});
      write_register(CSR_INDEX_BITS'($urandom_range(int'(skns_pkg::CSR_UPPER_MARGIN) + 1,
                                                    (1 << CSR_INDEX_BITS) - 1)),
                     DATA_WIDTH'($urandom));
      cur_lower = longint'($signed(lower[DATA_WIDTH-1:0]));
      cur_upper = longint'($signed(upper[DATA_WIDTH-1:0]));
      cur_lower_margin = longint'(lower_margin[MARGIN_WIDTH-1:0]);
      cur_upper_margin = longint'(upper_margin[MARGIN_WIDTH-1:0]);
      settings_applied++;
   endtask

   initial begin
      longint lower;
      longint upper;
      longint lower_margin;
      longint upper_margin;
      longint swap;
      int     scale;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.sample = '0;
      csr_if.valid = 1'b0;
      csr_if.index = skns_pkg::CSR_LOWER_LEVEL;
      csr_if.data = '0;
      send_idle_pct = 19;
      recv_idle_pct = 66;
      cur_lower = 0;
      cur_upper = LEVEL_MAX;
      cur_lower_margin = 0;
      cur_upper_margin = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_sample(LEVEL_MIN);
      send_sample(LEVEL_MAX);
      send_sample(0);
      send_sample(-1);
      send_sample(1);

      apply_setting(-100 * Q_ONE, 100 * Q_ONE, 2 * Q_ONE, 3 * Q_ONE);
      send_sample(cur_lower - cur_lower_margin - 1);
      send_sample(cur_lower - cur_lower_margin);
      send_sample(cur_lower);
      send_sample(cur_lower + cur_lower_margin - 1);
      send_sample(cur_lower + cur_lower_margin);
      send_sample(0);
      send_sample(cur_upper - cur_upper_margin - 1);
      send_sample(cur_upper - cur_upper_margin);
      send_sample(cur_upper);
      send_sample(cur_upper + cur_upper_margin - 1);
      send_sample(cur_upper + cur_upper_margin);

      // Inverted levels with full margins; the lower knee overshoots the top.
      apply_setting(LEVEL_MAX, LEVEL_MIN, MARGIN_MAX, MARGIN_MAX);
      send_sample(LEVEL_MAX);
      send_sample(cur_lower - cur_lower_margin);
      send_sample(LEVEL_MIN);

      // Empty lower knee; the upper knee undershoots the bottom.
      apply_setting(LEVEL_MIN, LEVEL_MIN, 0, MARGIN_MAX);
      send_sample(LEVEL_MIN);
      send_sample(0);
      send_sample(LEVEL_MAX);

      // Knees that overlap around zero.
      apply_setting(-Q_ONE / 2, Q_ONE / 2, 2 * Q_ONE, 2 * Q_ONE);
      send_sample(-Q_ONE);
      send_sample(0);
      send_sample(Q_ONE);

      for (int setting = 0; setting < SETTING_COUNT; setting++) begin
         if (setting == 3) begin
            send_idle_pct = 66;
            recv_idle_pct = 19;
         end
         if (setting == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (setting)
            0: apply_setting(LEVEL_MIN, LEVEL_MAX, MARGIN_MAX, MARGIN_MAX);
            6: apply_setting(spread(LEVEL_MAX), spread(LEVEL_MAX), 0, 0);
            7: apply_setting(LEVEL_MAX, LEVEL_MIN, MARGIN_MAX,
                             longint'($urandom_range(0, 255)));
            default: begin
               scale = $urandom_range(4, 31);
               lower = spread((longint'(1) << scale) - 1);
               upper = lower + longint'($urandom_range(0, 32'((longint'(1) << scale) - 1)));
               lower_margin = ($urandom_range(0, 4) == 0) ? 0 : longint'($urandom_range(0,
                  32'((longint'(1) << $urandom_range(0, MARGIN_WIDTH)) - 1)));
               upper_margin = ($urandom_range(0, 4) == 0) ? 0 : longint'($urandom_range(0,
                  32'((longint'(1) << $urandom_range(0, MARGIN_WIDTH)) - 1)));
               if ($urandom_range(0, 5) == 0) begin
                  swap = lower;
                  lower = upper;
                  upper = swap;
               end
               apply_setting(lower, upper, lower_margin, upper_margin);
            end
         endcase
         if (setting == 1) begin
            hold_request = 1;
         end
         for (int n = 0; n < SAMPLES_PER_SETTING; n++) begin
            if (setting == 4 && n == SAMPLES_PER_SETTING / 2) begin
               wait_drained();
            end
            send_sample(pick_sample());
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Sent %0d samples under %0d register settings, %0d levels compared.",
               samples_sent, settings_applied, levels_compared);
      $display("Knee regions reached: %0d lower, %0d upper.", low_knee_hits, high_knee_hits);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
